// File: design/utf8va_pkg.sv
// Shared types, constants and the accent lookup for the UTF-8 to ASCII transliterator.
package utf8va_pkg;

   // Default depth of the queue between classifier and emitter
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Capacity register value after reset
   localparam logic [7:0] CAPACITY_RESET = 8'd63;

   // Lead byte classes
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;

   // Substitute character for anything that cannot be mapped
   localparam logic [6:0]  ASCII_QMARK  = 7'h3F;
   localparam logic [15:0] CP_QMARK     = 16'h003F;
   localparam logic [15:0] CP_ASCII_TOP = 16'd128;

   // One classified request handed from front to back
   typedef struct packed {
      logic [15:0] codepoint;
      logic        emit;
      logic        last;
   } utf8va_entry_type;

   // Map a code point to its base ASCII letter; ASCII passes, others give '?'
   function automatic logic [6:0] to_ascii(input logic [15:0] cp);
      logic [6:0] c;
      case (cp)
         16'h00E0, 16'h00E1, 16'h1EA3, 16'h00E3, 16'h1EA1,
         16'h0103, 16'h1EAF, 16'h1EB1, 16'h1EB3, 16'h1EB5, 16'h1EB7,
         16'h00E2, 16'h1EA5, 16'h1EA7, 16'h1EA9, 16'h1EAB, 16'h1EAD: c = 7'h61;
         16'h00E8, 16'h00E9, 16'h1EBB, 16'h1EBD, 16'h1EB9,
         16'h00EA, 16'h1EBF, 16'h1EC1, 16'h1EC3, 16'h1EC5, 16'h1EC7: c = 7'h65;
         16'h00EC, 16'h00ED, 16'h1EC9, 16'h0129, 16'h1ECB:           c = 7'h69;
         16'h00F2, 16'h00F3, 16'h1ECF, 16'h00F5, 16'h1ECD,
         16'h00F4, 16'h1ED1, 16'h1ED3, 16'h1ED5, 16'h1ED7, 16'h1ED9,
         16'h01A1, 16'h1EDB, 16'h1EDD, 16'h1EDF, 16'h1EE1, 16'h1EE3: c = 7'h6F;
         16'h00F9, 16'h00FA, 16'h1EE7, 16'h0169, 16'h1EE5,
         16'h01B0, 16'h1EE9, 16'h1EEB, 16'h1EED, 16'h1EEF, 16'h1EF1: c = 7'h75;
         16'h00FD, 16'h1EF3, 16'h1EF7, 16'h1EF9, 16'h1EF5:           c = 7'h79;
         16'h00C0, 16'h00C1, 16'h1EA2, 16'h00C3, 16'h1EA0,
         16'h0102, 16'h1EAE, 16'h1EB0, 16'h1EB2, 16'h1EB4, 16'h1EB6,
         16'h00C2, 16'h1EA4, 16'h1EA6, 16'h1EA8, 16'h1EAA, 16'h1EAC: c = 7'h41;
         16'h00C8, 16'h00C9, 16'h1EBA, 16'h1EBC, 16'h1EB8,
         16'h00CA, 16'h1EBE, 16'h1EC0, 16'h1EC2, 16'h1EC4, 16'h1EC6: c = 7'h45;
         16'h00CC, 16'h00CD, 16'h1EC8, 16'h0128, 16'h1ECA:           c = 7'h49;
         16'h00D2, 16'h00D3, 16'h1ECE, 16'h00D5, 16'h1ECC,
         16'h00D4, 16'h1ED0, 16'h1ED2, 16'h1ED4, 16'h1ED6, 16'h1ED8,
         16'h01A0, 16'h1EDA, 16'h1EDC, 16'h1EDE, 16'h1EE0, 16'h1EE2: c = 7'h4F;
         16'h00D9, 16'h00DA, 16'h1EE6, 16'h0168, 16'h1EE4,
         16'h01AF, 16'h1EE8, 16'h1EEA, 16'h1EEC, 16'h1EEE, 16'h1EF0: c = 7'h55;
         16'h00DD, 16'h1EF2, 16'h1EF6, 16'h1EF8, 16'h1EF4:           c = 7'h59;
         16'h0111: c = 7'h64;
         16'h0110: c = 7'h44;
         default: begin
            if (cp < CP_ASCII_TOP) c = cp[6:0];
            else c = ASCII_QMARK;
         end
      endcase
      return c;
   endfunction

endpackage

// File: design/utf8va_front.sv
// Front end: accepts bytes, decodes UTF-8 sequences and tracks string state.
module utf8va_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_out_capacity,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   input  logic                      queue_full,
   output logic                      push_valid,
   output utf8va_pkg::utf8va_entry_type push_entry
);
   import utf8va_pkg::*;

   logic [7:0]  capacity_ff, capacity_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  pending_ff, pending_in;
   logic [7:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;

   logic        req_fire;
   logic        have;
   logic [15:0] cp;
   logic        emit;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign req_fire  = req_valid && req_ready;

   // Take capacity writes
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid) capacity_in = csr_out_capacity;
   end

   // Decode one byte and decide what goes to the back end
   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      have       = 1'b0;
      cp         = '0;
      emit       = 1'b0;
      push_valid = 1'b0;
      if (req_fire) begin
         if (!stopped_ff) begin
            if (pending_ff != 2'd0) begin
               partial_in = {partial_ff[9:0], req_data_byte[5:0]};
               pending_in = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  have = 1'b1;
                  cp   = partial_in;
               end
            end else if (req_data_byte == 8'd0 || count_ff >= capacity_ff) begin
               stopped_in = 1'b1;
            end else if (!req_data_byte[7]) begin
               have = 1'b1;
               cp   = {8'd0, req_data_byte};
            end else if ((req_data_byte & LEAD2_MASK) == LEAD2_CODE) begin
               partial_in = {11'd0, req_data_byte[4:0]};
               pending_in = 2'd1;
            end else if ((req_data_byte & LEAD3_MASK) == LEAD3_CODE) begin
               partial_in = {12'd0, req_data_byte[3:0]};
               pending_in = 2'd2;
            end else begin
               have = 1'b1;
               cp   = CP_QMARK;
            end
         end
         // A decoded zero never maps to a nonzero letter, so drop it here
         emit = have && (cp != 16'd0) && (count_ff < capacity_ff);
         if (emit) count_in = count_ff + 8'd1;
         push_valid = emit || req_last_byte;
         if (req_last_byte) begin
            partial_in = '0;
            pending_in = '0;
            count_in   = '0;
            stopped_in = 1'b0;
         end
      end
      push_entry.codepoint = cp;
      push_entry.emit      = emit;
      push_entry.last      = req_last_byte;
   end

   // Hold string state and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         partial_ff  <= '0;
         pending_ff  <= '0;
         count_ff    <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         partial_ff  <= partial_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

// File: design/utf8va_queue.sv
// Small register queue between the front end and the back end.
module utf8va_queue #(
   parameter int QUEUE_DEPTH = utf8va_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  utf8va_pkg::utf8va_entry_type push_entry,
   output logic                         full,
   input  logic                         pop_ready,
   output logic                         pop_valid,
   output utf8va_pkg::utf8va_entry_type pop_entry
);
   import utf8va_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   utf8va_entry_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: design/utf8va_back.sv
// Back end: maps code points to ASCII and emits characters and terminators.
module utf8va_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  utf8va_pkg::utf8va_entry_type pop_entry,
   output logic                         pop_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [6:0]                   rsp_out_char,
   output logic                         rsp_string_end
);
   import utf8va_pkg::*;

   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       end_ff, end_in;
   logic       term_ff, term_in;
   logic       slot_free;

   assign slot_free      = !valid_ff || rsp_ready;
   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_string_end = end_ff;

   // Load the output register: owed terminator first, then the queue head
   always_comb begin
      valid_in  = valid_ff;
      char_in   = char_ff;
      end_in    = end_ff;
      term_in   = term_ff;
      pop_ready = 1'b0;
      if (slot_free) begin
         valid_in = 1'b0;
         if (term_ff) begin
            valid_in = 1'b1;
            char_in  = '0;
            end_in   = 1'b1;
            term_in  = 1'b0;
         end else if (pop_valid) begin
            pop_ready = 1'b1;
            if (pop_entry.emit) begin
               valid_in = 1'b1;
               char_in  = to_ascii(pop_entry.codepoint);
               end_in   = 1'b0;
               term_in  = pop_entry.last;
            end else if (pop_entry.last) begin
               valid_in = 1'b1;
               char_in  = '0;
               end_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         term_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         term_ff  <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff  <= end_in;
   end

endmodule

// File: design/utf8_vietnamese_to_ascii.sv
// UTF-8 Vietnamese to ASCII transliterator; each result is registered after the queue.
// Throughput one request per cycle while the queue is not full; a request that
// yields a character and a terminator sends both in turn through the single output port.
// The request queue lets the decoder keep accepting while results wait to be taken.
// Reset clears string state and the queue and sets the capacity register to 63.
module utf8_vietnamese_to_ascii #(
   parameter int QUEUE_DEPTH = utf8va_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_out_capacity,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_string_end
);
   import utf8va_pkg::*;

   logic             queue_full;
   logic             push_valid;
   utf8va_entry_type push_entry;
   logic             pop_valid;
   logic             pop_ready;
   utf8va_entry_type pop_entry;

   // Decode and classify requests
   utf8va_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_out_capacity (csr_out_capacity),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // Buffer classified requests
   utf8va_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Map and emit results
   utf8va_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_entry      (pop_entry),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_string_end (rsp_string_end)
   );

endmodule
